// ===== design/assert_macros.svh =====
// assertion macros used by the checker file taa_checker.sv
// clocked on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent holds in the clock after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/taa_pkg.sv =====
// package for the tilt angle core: parameter defaults, cordic angle table
// and the quadrant flag type; used by the core and its checker
package taa_pkg;

  localparam int SAMPLE_BITS_DEF         = 16;
  localparam int CORDIC_STAGES_DEF       = 16;
  localparam int ANGLE_FRACTION_BITS_DEF = 6;

  // angle table in degrees with TABLE_FRAC fraction bits
  localparam int TABLE_FRAC = 24;
  localparam int TABLE_LEN  = 24;
  localparam int ZW         = 33;

  localparam logic [31:0] ATAN_DEG_TAB [TABLE_LEN] = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
    32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
    32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
    32'd234684,    32'd117342,    32'd58671,     32'd29335,
    32'd14668,     32'd7334,      32'd3667,      32'd1833,
    32'd917,       32'd458,       32'd229,       32'd115
  };

  localparam logic [31:0] Z_MAX = 32'd1509949440;

  typedef struct packed {
    logic x_neg;
    logic y_neg;
    logic x_zero;
    logic y_zero;
  } quad_t;

endpackage

// ===== design/tilt_angle_from_accel_core.sv =====
// tilt angle core: pipelined cordic atan2 in degrees with board tilt
// depends on taa_pkg
//
// usage:
//   slave stream takes one accelerometer pair per word, master stream
//   gives vector angle and tilt in 2^-ANGLE_FRACTION_BITS degree units
//   (1/64 degree by default)
//   one word in per cycle while the pipeline is not stalled; on its way to
//   master tvalid a word passes the input register, which loads at the accept
//   edge, then one register per cordic iteration, a clamp and round stage
//   and the output register
//   the chain of cordic iteration registers sets the latency
//   each stage holds while the stage after it is full and stalled, so
//   empty stages keep filling while the receiver stalls; s_axis_tready
//   drops only once every stage holds a word
//   reset clears all valid bits; no word is lost or repeated on a stall
//   x<0,y=0 gives 180 degrees, the origin gives 0 degrees
module tilt_angle_from_accel_core #(
  parameter int SAMPLE_BITS         = taa_pkg::SAMPLE_BITS_DEF,
  parameter int CORDIC_STAGES       = taa_pkg::CORDIC_STAGES_DEF,
  parameter int ANGLE_FRACTION_BITS = taa_pkg::ANGLE_FRACTION_BITS_DEF,
  localparam int AW    = ANGLE_FRACTION_BITS + 9,
  localparam int IN_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * AW + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // accel_x, accel_y
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // vector_angle, tilt_angle
  output logic [OUT_W-1:0] m_axis_tdata
);

  localparam int N     = CORDIC_STAGES;
  localparam int SB    = SAMPLE_BITS;
  localparam int W     = SB + N + 2;
  localparam int ZW    = taa_pkg::ZW;
  localparam int SH    = taa_pkg::TABLE_FRAC - ANGLE_FRACTION_BITS;
  localparam int TW    = AW + 2;
  localparam int LAST  = N + 1;

  localparam logic [AW-1:0] FULL = AW'(360 << ANGLE_FRACTION_BITS);
  localparam logic [AW-1:0] HALF = AW'(180 << ANGLE_FRACTION_BITS);
  localparam logic [AW-1:0] Q3   = AW'(270 << ANGLE_FRACTION_BITS);
  localparam logic signed [TW-1:0] Q1_S   = TW'(90 << ANGLE_FRACTION_BITS);
  localparam logic signed [TW-1:0] T_BASE = TW'(450 << ANGLE_FRACTION_BITS);
  localparam logic [ZW-1:0] RND = ZW'(1) << (SH - 1);

  logic [LAST+1:0] en;
  logic [LAST:0]   v_q;

  logic signed [W-1:0]  cx_q [N+1];
  logic signed [W-1:0]  cy_q [N+1];
  logic signed [ZW-1:0] z_q  [N+1];
  taa_pkg::quad_t       fl_q [LAST+1];

  logic [AW-1:0] a_q;
  logic          out_valid_q;
  logic [AW-1:0] vec_q, vec_d;
  logic [AW-1:0] tilt_q, tilt_d;

  always_comb begin
    en[LAST+1] = !out_valid_q || m_axis_tready;
    for (int k = LAST; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];

  // input stage
  logic signed [SB-1:0] x_s, y_s;
  logic [SB-1:0]        ax, ay;
  assign x_s = $signed(s_axis_tdata[SB-1:0]);
  assign y_s = $signed(s_axis_tdata[2*SB-1:SB]);
  assign ax  = x_s[SB-1] ? (~x_s + SB'(1)) : x_s;
  assign ay  = y_s[SB-1] ? (~y_s + SB'(1)) : y_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en[0]) begin
      v_q[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      cx_q[0]        <= $signed({2'b00, ax, {N{1'b0}}});
      cy_q[0]        <= $signed({2'b00, ay, {N{1'b0}}});
      z_q[0]         <= '0;
      fl_q[0].x_neg  <= x_s[SB-1];
      fl_q[0].y_neg  <= y_s[SB-1];
      fl_q[0].x_zero <= (x_s == '0);
      fl_q[0].y_zero <= (y_s == '0);
    end
  end

  // cordic iterations, one register stage each
  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam logic signed [ZW-1:0] ANG = $signed({1'b0, taa_pkg::ATAN_DEG_TAB[i]});
    logic signed [W-1:0] dx, dy;
    assign dx = cy_q[i] >>> i;
    assign dy = cx_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en[i+1]) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[i+1]) begin
        fl_q[i+1] <= fl_q[i];
        if (!cy_q[i][W-1]) begin
          cx_q[i+1] <= cx_q[i] + dx;
          cy_q[i+1] <= cy_q[i] - dy;
          z_q[i+1]  <= z_q[i] + ANG;
        end else begin
          cx_q[i+1] <= cx_q[i] - dx;
          cy_q[i+1] <= cy_q[i] + dy;
          z_q[i+1]  <= z_q[i] - ANG;
        end
      end
    end
  end

  // clamp and round stage
  logic [31:0]   zc;
  logic [ZW-1:0] zr;
  always_comb begin
    if (z_q[N][ZW-1]) begin
      zc = '0;
    end else if (z_q[N][31:0] > taa_pkg::Z_MAX) begin
      zc = taa_pkg::Z_MAX;
    end else begin
      zc = z_q[N][31:0];
    end
    zr = {1'b0, zc} + RND;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[LAST] <= 1'b0;
    end else if (en[LAST]) begin
      v_q[LAST] <= v_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[LAST]) begin
      a_q        <= zr[ZW-1:SH];
      fl_q[LAST] <= fl_q[N];
    end
  end

  // quadrant mapping and tilt
  // tilt is 450 - angle above three quarters of a turn, else 90 - angle
  logic [AW-1:0]        v_raw;
  logic signed [TW-1:0] t_s;
  always_comb begin
    if (fl_q[LAST].y_zero) begin
      v_raw = (fl_q[LAST].x_neg && !fl_q[LAST].x_zero) ? HALF : '0;
    end else if (!fl_q[LAST].x_neg && !fl_q[LAST].y_neg) begin
      v_raw = a_q;
    end else if (fl_q[LAST].x_neg && !fl_q[LAST].y_neg) begin
      v_raw = HALF - a_q;
    end else if (fl_q[LAST].x_neg) begin
      v_raw = HALF + a_q;
    end else begin
      v_raw = FULL - a_q;
    end
    vec_d = (v_raw >= FULL) ? (v_raw - FULL) : v_raw;
    t_s = ((vec_d > Q3) ? T_BASE : Q1_S) - $signed({2'b00, vec_d});
    tilt_d = t_s[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en[LAST+1]) begin
      out_valid_q <= v_q[LAST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[LAST+1]) begin
      vec_q  <= vec_d;
      tilt_q <= tilt_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({tilt_q, vec_q});

endmodule

// ===== design/taa_checker.sv =====
// port-level checker for the tilt angle core, bound to tilt_angle_from_accel_core
// depends on taa_pkg and assert_macros.svh
`include "assert_macros.svh"

module taa_checker #(
  parameter int SAMPLE_BITS         = taa_pkg::SAMPLE_BITS_DEF,
  parameter int CORDIC_STAGES       = taa_pkg::CORDIC_STAGES_DEF,
  parameter int ANGLE_FRACTION_BITS = taa_pkg::ANGLE_FRACTION_BITS_DEF,
  localparam int AW    = ANGLE_FRACTION_BITS + 9,
  localparam int IN_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * AW + 7) / 8) * 8
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic [IN_W-1:0]  s_axis_tdata,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  localparam int TW = AW + 2;
  localparam logic [AW-1:0] FULL = AW'(360 << ANGLE_FRACTION_BITS);
  localparam logic signed [TW-1:0] FULL_S = TW'(360 << ANGLE_FRACTION_BITS);
  localparam logic signed [TW-1:0] HALF_S = TW'(180 << ANGLE_FRACTION_BITS);
  localparam logic signed [TW-1:0] T_BASE = TW'(450 << ANGLE_FRACTION_BITS);

  logic [AW-1:0]        vec;
  logic [AW-1:0]        tilt;
  logic signed [TW-1:0] t0, t1, t2;
  logic                 in_seen;

  assign vec  = m_axis_tdata[AW-1:0];
  assign tilt = m_axis_tdata[2*AW-1:AW];
  assign in_seen = s_axis_tvalid && (s_axis_tdata == s_axis_tdata);

  always_comb begin
    t0 = T_BASE - $signed({2'b00, vec});
    t1 = (t0 > FULL_S) ? (t0 - FULL_S) : t0;
    t2 = (t1 >= HALF_S) ? (t1 - FULL_S) : t1;
  end

  `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "output word changed while stalled")
  `ASSERT_ALWAYS(a_vec_range, !m_axis_tvalid || (vec < FULL), "vector angle out of range")
  `ASSERT_ALWAYS(a_tilt_match, !m_axis_tvalid || (tilt == t2[AW-1:0]),
    "tilt does not match vector angle")
  `ASSERT_ALWAYS(a_ready_empty, m_axis_tvalid || s_axis_tready || !in_seen,
    "input stalled with empty output")

endmodule

bind tilt_angle_from_accel_core taa_checker #(
  .SAMPLE_BITS        (SAMPLE_BITS),
  .CORDIC_STAGES      (CORDIC_STAGES),
  .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)
) u_taa_checker (.*);
